### rtl/and_or_game_distance_solver_defines.svh
// Assertion macros shared by the solver RTL.
`ifndef AND_OR_GAME_DISTANCE_SOLVER_DEFINES_SVH
`define AND_OR_GAME_DISTANCE_SOLVER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define AOGD_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define AOGD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

### rtl/aogd_pkg.sv
package aogd_pkg;
	localparam int MaxStates  = 32;
	localparam int MaxOptions = 16;
	localparam int SW = $clog2(MaxStates);
	localparam int OW = $clog2(MaxOptions);
	localparam int TW = SW + OW;
	localparam int CW = $clog2(MaxOptions + 1);

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_SOLVE = 2'd2;

	localparam logic [5:0] MOVES_NONE = 6'h3f;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [4:0]  state_index;
		logic [31:0] option_mask;
	} req_t;

	typedef struct packed {
		logic        status;
		logic [4:0]  start_state;
		logic [5:0]  moves;
		logic        last;
	} rsp_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic          clr_counts;
		logic          load;       // append option_mask to state_index list
		logic          init_dist;  // mark all unreachable, seed target
		logic          rd_opt;     // issue table read for (p, i)
		logic          eval;       // evaluate registered option for p_eval
		logic [SW-1:0] p;
		logic [OW-1:0] i;
		logic [SW-1:0] p_eval;
		logic          walk_start;
		logic          walk_step;
	} cmd_t;

	typedef struct packed {
		logic          full;       // owner list is full
		logic [CW-1:0] count;      // option count of p
		logic          walk_done;
		logic          changed;    // distance improved on this eval
	} sts_t;
endpackage

### rtl/aogd_if.sv
interface aogd_req_if import aogd_pkg::*; (input logic clk);
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface aogd_rsp_if import aogd_pkg::*; (input logic clk);
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### rtl/aogd_ram.sv
module aogd_ram #(
	parameter int Width = 32,
	parameter int Depth = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/aogd_datapath.sv
module aogd_datapath import aogd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  cmd_t          cmd,
	input  logic [4:0]    state_index,
	input  logic [31:0]   option_mask,
	input  logic [31:0]   active_mask,
	input  logic [SW-1:0] out_p,
	output sts_t          sts,
	output logic          out_valid_dist,
	output logic [5:0]    out_dist
);
	logic [CW-1:0]       count_q [MaxStates];
	logic [MaxStates-1:0] valid_q;
	logic [5:0]          dist_q [MaxStates];
	logic [31:0]         rdata;
	logic [31:0]         walk_q;
	logic                ok_q;
	logic [5:0]          worst_q;
	logic                any_q;
	logic [SW-1:0]       s_idx;
	logic [31:0]         low_bit;
	logic                wr_ok;

	aogd_ram #(.Width(32), .Depth(MaxStates * MaxOptions)) u_table (
		.clk   (clk),
		.we    (cmd.load && wr_ok),
		.waddr ({state_index, count_q[state_index][OW-1:0]}),
		.wdata (option_mask),
		.raddr ({cmd.p, cmd.i}),
		.rdata (rdata)
	);

	assign wr_ok = count_q[state_index] < CW'(MaxOptions);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MaxStates; k++) begin
				count_q[k] <= '0;
			end
		end else if (cmd.clr_counts) begin
			for (int k = 0; k < MaxStates; k++) begin
				count_q[k] <= '0;
			end
		end else if (cmd.load && wr_ok) begin
			count_q[state_index] <= count_q[state_index] + CW'(1);
		end
	end

	// One set member per cycle: lowest set bit of the remaining mask.
	assign low_bit = walk_q & (~walk_q + 32'd1);
	always_comb begin
		s_idx = '0;
		for (int k = 0; k < MaxStates; k++) begin
			if (low_bit[k]) begin
				s_idx = SW'(k);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.walk_start) begin
			walk_q  <= rdata & active_mask;
			ok_q    <= 1'b1;
			worst_q <= '0;
			any_q   <= (rdata & active_mask) != 32'd0;
		end else if (cmd.walk_step && walk_q != 32'd0) begin
			walk_q <= walk_q & ~low_bit;
			if (!valid_q[s_idx]) begin
				ok_q <= 1'b0;
			end else if (dist_q[s_idx] > worst_q) begin
				worst_q <= dist_q[s_idx];
			end
		end
	end

	logic [5:0] cand;
	logic       better;
	assign cand   = worst_q + 6'd1;
	assign better = ok_q && any_q && (!valid_q[cmd.p_eval] || cand < dist_q[cmd.p_eval]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.init_dist) begin
			valid_q <= '0;
			if (active_mask[state_index]) begin
				valid_q[state_index] <= 1'b1;
			end
		end else if (cmd.eval && better) begin
			valid_q[cmd.p_eval] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.init_dist) begin
			dist_q[state_index] <= '0;
		end else if (cmd.eval && better) begin
			dist_q[cmd.p_eval] <= cand;
		end
	end

	assign sts.full      = !wr_ok;
	assign sts.count     = count_q[cmd.p];
	assign sts.walk_done = walk_q == 32'd0 || !ok_q;
	assign sts.changed   = cmd.eval && better;
	assign out_valid_dist = valid_q[out_p];
	assign out_dist       = dist_q[out_p];
endmodule

### rtl/aogd_ctrl.sv
`include "and_or_game_distance_solver_defines.svh"
module aogd_ctrl import aogd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    req_type,
	input  logic [SW:0]   n_act,
	input  sts_t          sts,
	output cmd_t          cmd,
	output logic          emit,
	output logic          emit_ack,
	output logic          emit_status,
	output logic [SW-1:0] out_p,
	output logic          emit_last,
	input  logic          out_free
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_WAIT = 3'd2;
	localparam logic [2:0] ST_WALK = 3'd3;
	localparam logic [2:0] ST_EMIT = 3'd4;

	logic [2:0]    state_q;
	logic [SW-1:0] p_q;
	logic [OW:0]   i_q;
	logic          chg_q;
	logic          accept;

	assign in_ready = state_q == ST_IDLE && out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		cmd.p      = p_q;
		cmd.i      = i_q[OW-1:0];
		cmd.p_eval = p_q;
		cmd.clr_counts = accept && req_type == REQ_CLEAR;
		cmd.load       = accept && req_type == REQ_LOAD;
		cmd.init_dist  = accept && req_type == REQ_SOLVE;
		cmd.walk_start = state_q == ST_WAIT;
		cmd.walk_step  = state_q == ST_WALK;
		cmd.eval       = state_q == ST_WALK && sts.walk_done;
	end

	assign emit        = (accept && (req_type == REQ_CLEAR || req_type == REQ_LOAD))
		|| (state_q == ST_EMIT && out_free);
	assign emit_ack    = state_q != ST_EMIT;
	assign emit_status = req_type == REQ_LOAD && sts.full;
	assign out_p       = p_q;
	assign emit_last   = emit_ack || {1'b0, p_q} + (SW+1)'(1) == n_act;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			p_q     <= '0;
			i_q     <= '0;
			chg_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req_type == REQ_SOLVE) begin
						p_q     <= '0;
						i_q     <= '0;
						chg_q   <= 1'b0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					if (i_q >= (OW+1)'(sts.count) || i_q == (OW+1)'(MaxOptions)) begin
						i_q <= '0;
						if ({1'b0, p_q} + (SW+1)'(1) >= n_act) begin
							p_q <= '0;
							if (chg_q) begin
								chg_q <= 1'b0;
							end else begin
								state_q <= ST_EMIT;
							end
						end else begin
							p_q <= p_q + SW'(1);
						end
					end else begin
						state_q <= ST_WAIT;
					end
				end
				ST_WAIT: state_q <= ST_WALK;
				ST_WALK: begin
					if (sts.walk_done) begin
						if (sts.changed) begin
							chg_q <= 1'b1;
						end
						i_q     <= i_q + (OW+1)'(1);
						state_q <= ST_RD;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							p_q <= p_q + SW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`AOGD_ASSERT_IMPL(a_no_accept_busy, state_q != ST_IDLE, !in_ready)
	`AOGD_ASSERT_NEXT(a_solve_starts, accept && req_type == REQ_SOLVE, state_q == ST_RD)
	`AOGD_ASSERT_IMPL(a_emit_needs_room, emit, out_free)
endmodule

### rtl/and_or_game_distance_solver.sv
// Channel   Dir  Payload
// req       in   req_type, state_index, option_mask
// rsp       out  status, start_state, moves, last
// cfg       in   num_states (write enable and data)
// Clear and load give one result each. A solve sweeps every active state's
// options: each option is read (RD), its walk started (WAIT) and its set
// members walked (WALK), stopping early at an unreachable member; each state
// ends on a read past its list. Sweeps repeat until a sweep changes nothing,
// then one result per cycle is sent while taken. Reset clears option counts,
// distance valid flags and the result valid flag; the table is written
// before read. A stalled result holds the output register and blocks new
// requests; the sweep itself never waits on the output.
module and_or_game_distance_solver import aogd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [5:0]  cfg_wdata,
	aogd_req_if.sink    req,
	aogd_rsp_if.source  rsp
);
	logic [5:0]    num_q;
	logic [SW:0]   n_act;
	logic [31:0]   active_mask;
	cmd_t          cmd;
	sts_t          sts;
	logic          emit, emit_ack, emit_status, emit_last;
	logic [SW-1:0] out_p;
	logic          dvalid;
	logic [5:0]    dval;
	logic          out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= 6'd32;
		end else if (cfg_we) begin
			num_q <= cfg_wdata;
		end
	end

	// Zero acts as one state; anything above the maximum is clamped.
	always_comb begin
		priority if (num_q == 6'd0) begin
			n_act = (SW+1)'(1);
		end else if (num_q > 6'(MaxStates)) begin
			n_act = (SW+1)'(MaxStates);
		end else begin
			n_act = num_q[SW:0];
		end
	end
	always_comb begin
		for (int k = 0; k < 32; k++) begin
			active_mask[k] = k < int'(n_act);
		end
	end

	// Output register: free when empty or being taken this cycle.
	assign out_free = !rsp.valid || rsp.ready;

	aogd_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid (req.valid), .in_ready (req.ready),
		.req_type (req.data.req_type),
		.n_act, .sts, .cmd, .emit, .emit_ack, .emit_status,
		.out_p, .emit_last, .out_free
	);

	aogd_datapath u_dp (
		.clk, .arst_n, .cmd,
		.state_index (req.data.state_index),
		.option_mask (req.data.option_mask),
		.active_mask, .out_p, .sts,
		.out_valid_dist (dvalid), .out_dist (dval)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.valid <= 1'b0;
		end else if (emit) begin
			rsp.valid <= 1'b1;
		end else if (rsp.ready) begin
			rsp.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp.data.status      <= emit_ack && emit_status;
			rsp.data.start_state <= emit_ack ? 5'd0 : 5'(out_p);
			rsp.data.moves       <= emit_ack ? 6'd0 : (dvalid ? dval : MOVES_NONE);
			rsp.data.last        <= emit_last;
		end
	end
endmodule
